// ----- rtl/core/kpc_pkg.sv -----
`timescale 1ns / 1ps

package kpc_pkg;

    // register port geometry
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int COUNT_WIDTH_DEF = 16;

    // reset values of the registers
    localparam logic [CFG_W-1:0] CHANGE_TIME_RST      = 16'd5;
    localparam logic [CFG_W-1:0] LONG_CHANGE_TIME_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANGE_TIME      = 1'b0,
        CFG_LONG_CHANGE_TIME = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_UP         = 3'd0,
        ST_PRESS      = 3'd1,
        ST_SHORT_HOLD = 3'd2,
        ST_DOWN       = 3'd3,
        ST_RELAX      = 3'd4
    } t_key_state;

    typedef struct packed {
        logic [CFG_W-1:0] change_time;
        logic [CFG_W-1:0] long_change_time;
    } t_cfg;

    typedef struct packed {
        logic key_level;
    } t_in_word;

    typedef struct packed {
        t_key_state key_state;
        logic       toggle_level;
        logic       one_shot;
    } t_out_word;

endpackage

// ----- rtl/core/kpc_if.sv -----
`timescale 1ns / 1ps

// sample channel
interface kpc_in_if;
    import kpc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result channel
interface kpc_out_if;
    import kpc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/kpc_classify.sv -----
`timescale 1ns / 1ps

module kpc_classify #(
    parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_level,
    input  kpc_pkg::t_cfg     i_cfg,
    output kpc_pkg::t_out_word o_word
);
    import kpc_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

    logic [COUNT_WIDTH-1:0] r_run_count, n_run_count;
    logic                   r_last_level;
    t_key_state             r_state, n_state;
    logic                   r_toggle, n_toggle;
    logic                   r_toggle_armed, n_toggle_armed;
    logic                   r_pulse_armed, n_pulse_armed;
    logic                   n_fire;

    logic [COUNT_WIDTH-1:0] cnt_base;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       short_lim;
    logic [CMP_W-1:0]       short_lim1;
    logic [CMP_W-1:0]       long_lim;

    // run counter: cleared on a level change, saturating increment
    assign cnt_base   = (i_level != r_last_level) ? '0 : r_run_count;
    assign cnt_inc    = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
    assign cnt_ext    = CMP_W'(cnt_inc);
    assign short_lim  = CMP_W'(i_cfg.change_time);
    assign short_lim1 = short_lim + 1'b1;
    assign long_lim   = CMP_W'(i_cfg.long_change_time);

    // next class state and count
    always_comb begin
        n_state     = r_state;
        n_run_count = cnt_base;
        if (!i_level) begin
            if (r_state != ST_UP) begin
                n_run_count = cnt_inc;
                if (cnt_ext >= short_lim1) begin
                    n_state = ST_UP;
                end else if (cnt_ext >= short_lim) begin
                    n_state = ST_RELAX;
                end
            end else begin
                n_run_count = '0;
            end
        end else begin
            if (r_state != ST_DOWN) begin
                n_run_count = cnt_inc;
                if (cnt_ext >= long_lim) begin
                    n_state = ST_DOWN;
                end else if (cnt_ext >= short_lim1) begin
                    n_state = ST_SHORT_HOLD;
                end else if (cnt_ext >= short_lim) begin
                    n_state = ST_PRESS;
                end
            end else begin
                n_run_count = '0;
            end
        end
    end

    // toggle and one-shot follow the new state
    always_comb begin
        n_toggle       = r_toggle;
        n_toggle_armed = r_toggle_armed;
        n_pulse_armed  = r_pulse_armed;
        n_fire         = 1'b0;
        unique case (n_state)
            ST_SHORT_HOLD: begin
                if (r_toggle_armed) begin
                    n_toggle       = ~r_toggle;
                    n_toggle_armed = 1'b0;
                end
                if (r_pulse_armed) begin
                    n_fire        = 1'b1;
                    n_pulse_armed = 1'b0;
                end
            end
            ST_RELAX: begin
                n_toggle_armed = 1'b1;
            end
            ST_PRESS: begin
                n_pulse_armed = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_word.key_state    = n_state;
    assign o_word.toggle_level = n_toggle;
    assign o_word.one_shot     = n_fire;

    // state update per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count    <= '0;
            r_last_level   <= 1'b0;
            r_state        <= ST_UP;
            r_toggle       <= 1'b0;
            r_toggle_armed <= 1'b1;
            r_pulse_armed  <= 1'b1;
        end else if (i_step) begin
            r_run_count    <= n_run_count;
            r_last_level   <= i_level;
            r_state        <= n_state;
            r_toggle       <= n_toggle;
            r_toggle_armed <= n_toggle_armed;
            r_pulse_armed  <= n_pulse_armed;
        end
    end

    // a fired pulse leaves the pulse disarmed
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_fire) |=> !r_pulse_armed)
        else $error("one-shot fired but stayed armed");

    // toggle only changes on a short hold word
    a_toggle_only_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (n_toggle != r_toggle)) |-> (n_state == ST_SHORT_HOLD))
        else $error("toggle changed outside short hold");

endmodule

// ----- rtl/core/kpc_out_buf.sv -----
`timescale 1ns / 1ps

module kpc_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  kpc_pkg::t_out_word i_word,
    output logic               o_can_push,
    output logic               o_valid,
    output kpc_pkg::t_out_word o_word,
    input  logic               i_ready
);
    import kpc_pkg::*;

    logic      r_out_vld, n_out_vld;
    logic      r_skid_vld, n_skid_vld;
    t_out_word r_out, n_out;
    t_out_word r_skid, n_skid;
    logic      pop;

    assign pop        = r_out_vld & i_ready;
    assign o_can_push = ~r_skid_vld;
    assign o_valid    = r_out_vld;
    assign o_word     = r_out;

    // two-entry output buffer: output register plus skid
    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (pop) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (i_push) begin
            if (!r_out_vld || (pop && !r_skid_vld)) begin
                n_out     = i_word;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = i_word;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // skid only holds a word behind a waiting output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    // a stalled word moves into skid, never overwrites the output
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_vld && !i_ready) |=> r_skid_vld)
        else $error("stalled word not kept in skid");

endmodule

// ----- rtl/core/key_press_classifier_core.sv -----
`timescale 1ns / 1ps

// Key press classifier: takes one sampled key level per word and returns one
// result word per sample with the key state (up, press, short hold, down,
// relax), a toggle level and a one-shot pulse. A new sample is accepted every
// clock cycle while the output buffer has room; its result is registered in
// the output buffer after the combinational counter compare logic. Results
// sit in a two-entry output buffer, so the input stalls only when two results
// are waiting downstream. The user must write thresholds through the register
// port only while no word is in flight; the block does not enforce this. The
// run counter is COUNT_WIDTH bits and saturates.
module key_press_classifier_core #(
    parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kpc_in_if.sink                      i_in,
    kpc_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  kpc_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [kpc_pkg::CFG_W-1:0]   i_cfg_data
);
    import kpc_pkg::*;

    t_cfg      r_cfg;
    t_out_word step_word;
    logic      can_push;
    logic      step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.change_time      <= CHANGE_TIME_RST;
            r_cfg.long_change_time <= LONG_CHANGE_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANGE_TIME:      r_cfg.change_time      <= i_cfg_data;
                CFG_LONG_CHANGE_TIME: r_cfg.long_change_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = can_push;
    assign step       = i_in.valid & can_push;

    kpc_classify #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_level (i_in.data.key_level),
        .i_cfg   (r_cfg),
        .o_word  (step_word)
    );

    kpc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (step),
        .i_word     (step_word),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .o_word     (o_out.data),
        .i_ready    (o_out.ready)
    );

endmodule
